/* rtl/tfs_pkg.sv */
// tfs_pkg: shared types and constants of the telemetry frame serializer
// no dependencies; imported by every module of the block
package tfs_pkg;

  localparam int BYTE_W = 8;
  localparam int VALUE_W = 32;
  localparam int NUM_VALUES = 10;
  localparam int MODE_W = 3;
  localparam int CFG_IDX_W = 2;

  // longest payload is the rc layout: ten 16-bit values
  localparam int MAX_PAYLOAD_BYTES = 20;
  localparam int PAYLOAD_W = MAX_PAYLOAD_BYTES * BYTE_W;
  localparam int LEN_W = 5;
  localparam int HDR_BYTES = 5;
  // byte position within a frame, up to header + payload + checksum - 1
  localparam int POS_W = 5;

  // message types
  localparam logic [MODE_W-1:0] MODE_STATUS  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SENSOR  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SENSOR2 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RC      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POWER   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MOTOR   = 3'd5;

  // function ids on the wire
  localparam logic [BYTE_W-1:0] FID_STATUS  = 8'h01;
  localparam logic [BYTE_W-1:0] FID_SENSOR  = 8'h02;
  localparam logic [BYTE_W-1:0] FID_SENSOR2 = 8'h07;
  localparam logic [BYTE_W-1:0] FID_RC      = 8'h03;
  localparam logic [BYTE_W-1:0] FID_POWER   = 8'h05;
  localparam logic [BYTE_W-1:0] FID_MOTOR   = 8'h06;

  // payload lengths in bytes
  localparam logic [LEN_W-1:0] LEN_STATUS  = 5'd12;
  localparam logic [LEN_W-1:0] LEN_SENSOR  = 5'd18;
  localparam logic [LEN_W-1:0] LEN_SENSOR2 = 5'd10;
  localparam logic [LEN_W-1:0] LEN_RC      = 5'd20;
  localparam logic [LEN_W-1:0] LEN_POWER   = 5'd4;
  localparam logic [LEN_W-1:0] LEN_MOTOR   = 5'd16;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;

  // header byte positions
  localparam logic [2:0] POS_SYNC = 3'd0;
  localparam logic [2:0] POS_SRC  = 3'd1;
  localparam logic [2:0] POS_TGT  = 3'd2;
  localparam logic [2:0] POS_FID  = 3'd3;
  localparam logic [2:0] POS_LEN  = 3'd4;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ADDRESS = 2'd1;
  localparam logic [BYTE_W-1:0] SOURCE_ADDRESS_RST = 8'h05;
  localparam logic [BYTE_W-1:0] TARGET_ADDRESS_RST = 8'hAF;

  // one classified message, payload left aligned, first byte in the top bits
  typedef struct packed {
    logic [BYTE_W-1:0]    fid;
    logic [LEN_W-1:0]     len;
    logic [PAYLOAD_W-1:0] payload;
  } frame_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic busy;
  } back_status_t;

endpackage

/* rtl/tfs_front.sv */
// tfs_front: classifies a message by type and packs its payload bytes
// depends on tfs_pkg; feeds tfs_queue
module tfs_front
  import tfs_pkg::*;
(
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 queue_full,
  input  logic [MODE_W-1:0]                    mode,
  input  logic [NUM_VALUES-1:0][VALUE_W-1:0]   values,
  output logic                                 push,
  output frame_desc_t                          desc
);

  logic known_mode;
  logic [VALUE_W-1:0] v0, v1, v2, v3, v4, v5, v6, v7, v8, v9;

  assign v0 = values[0];
  assign v1 = values[1];
  assign v2 = values[2];
  assign v3 = values[3];
  assign v4 = values[4];
  assign v5 = values[5];
  assign v6 = values[6];
  assign v7 = values[7];
  assign v8 = values[8];
  assign v9 = values[9];

  always_comb begin
    known_mode = 1'b1;
    desc = '0;
    unique case (mode)
      MODE_STATUS: begin
        desc.fid = FID_STATUS;
        desc.len = LEN_STATUS;
        desc.payload = {v0[15:0], v1[15:0], v2[15:0], v3, v4[7:0], v5[7:0], 64'd0};
      end
      MODE_SENSOR: begin
        desc.fid = FID_SENSOR;
        desc.len = LEN_SENSOR;
        desc.payload = {v0[15:0], v1[15:0], v2[15:0], v3[15:0], v4[15:0],
                        v5[15:0], v6[15:0], v7[15:0], v8[15:0], 16'd0};
      end
      MODE_SENSOR2: begin
        desc.fid = FID_SENSOR2;
        desc.len = LEN_SENSOR2;
        desc.payload = {v0, v1, v2[15:0], 80'd0};
      end
      MODE_RC: begin
        desc.fid = FID_RC;
        desc.len = LEN_RC;
        desc.payload = {v0[15:0], v1[15:0], v2[15:0], v3[15:0], v4[15:0],
                        v5[15:0], v6[15:0], v7[15:0], v8[15:0], v9[15:0]};
      end
      MODE_POWER: begin
        desc.fid = FID_POWER;
        desc.len = LEN_POWER;
        desc.payload = {v0[15:0], v1[15:0], 128'd0};
      end
      MODE_MOTOR: begin
        desc.fid = FID_MOTOR;
        desc.len = LEN_MOTOR;
        desc.payload = {v0[15:0], v1[15:0], v2[15:0], v3[15:0], v4[15:0],
                        v5[15:0], v6[15:0], v7[15:0], 32'd0};
      end
      default: begin
        known_mode = 1'b0;
      end
    endcase
  end

  // unknown types are taken and dropped, they make no frame
  assign push = in_valid && !queue_full && known_mode && !rst;

endmodule

/* rtl/tfs_queue.sv */
// tfs_queue: short fifo of classified messages between front and back
// depends on tfs_pkg
module tfs_queue
  import tfs_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frame_desc_t   wr_desc,
  input  logic          pop,
  output frame_desc_t   rd_desc,
  output queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  frame_desc_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign status.full = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop = pop && !status.empty;
  assign rd_desc = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/tfs_back.sv */
// tfs_back: walks one message through header, payload and checksum bytes
// depends on tfs_pkg; drains tfs_queue into the registered output beat
module tfs_back
  import tfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              queue_empty,
  input  frame_desc_t       rd_desc,
  output logic              pop,
  input  logic [BYTE_W-1:0] source_address,
  input  logic [BYTE_W-1:0] target_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] frame_byte,
  output logic              last_byte,
  output back_status_t      status
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic state;
  logic state_next;
  logic [POS_W-1:0] pos;
  logic [BYTE_W-1:0] sum;
  logic [BYTE_W-1:0] fid;
  logic [LEN_W-1:0] len;
  logic [PAYLOAD_W-1:0] payload;

  logic load;
  logic is_last;
  logic is_header;
  logic [BYTE_W-1:0] cur_byte;
  logic [BYTE_W-1:0] hdr_byte;

  assign status.busy = (state == ST_SEND);
  assign pop = (state == ST_IDLE) && !queue_empty;
  // output register free or emptied this cycle
  assign load = (state == ST_SEND) && (!out_valid || !out_stall);
  assign is_last = (pos == (POS_W'(len) + POS_W'(HDR_BYTES)));
  assign is_header = (pos < POS_W'(HDR_BYTES));

  always_comb begin
    unique case (pos[2:0])
      POS_SYNC: hdr_byte = SYNC_BYTE;
      POS_SRC:  hdr_byte = source_address;
      POS_TGT:  hdr_byte = target_address;
      POS_FID:  hdr_byte = fid;
      POS_LEN:  hdr_byte = BYTE_W'(len);
      default:  hdr_byte = '0;
    endcase
  end

  always_comb begin
    if (is_last) begin
      cur_byte = sum;
    end else if (is_header) begin
      cur_byte = hdr_byte;
    end else begin
      cur_byte = payload[PAYLOAD_W-1 -: BYTE_W];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!queue_empty) state_next = ST_SEND;
      ST_SEND: if (load && is_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fid <= rd_desc.fid;
      len <= rd_desc.len;
      payload <= rd_desc.payload;
      pos <= '0;
      sum <= '0;
    end else if (load) begin
      frame_byte <= cur_byte;
      last_byte <= is_last;
      sum <= sum + cur_byte;
      pos <= pos + 1'b1;
      // payload moves up one byte for each payload beat
      if (!is_header && !is_last) begin
        payload <= payload << BYTE_W;
      end
    end
  end

endmodule

/* rtl/telemetry_frame_serializer_unit.sv */
// telemetry_frame_serializer_unit: top level of the telemetry frame serializer
// a message beat is written into the queue, popped by the back and its first byte registered at out_valid
// throughput: a frame of n bytes (10 to 26) leaves one byte per cycle while out_stall is low;
// each message is first loaded from the queue, then sent byte by byte
// the front takes new messages until two wait in the queue
// reset (rst, synchronous): queue emptied, back idle, addresses back to 5 and 0xaf
module telemetry_frame_serializer_unit
  import tfs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_W-1:0]    mode,
  input  logic [VALUE_W-1:0]   value_0,
  input  logic [VALUE_W-1:0]   value_1,
  input  logic [VALUE_W-1:0]   value_2,
  input  logic [VALUE_W-1:0]   value_3,
  input  logic [VALUE_W-1:0]   value_4,
  input  logic [VALUE_W-1:0]   value_5,
  input  logic [VALUE_W-1:0]   value_6,
  input  logic [VALUE_W-1:0]   value_7,
  input  logic [VALUE_W-1:0]   value_8,
  input  logic [VALUE_W-1:0]   value_9,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    frame_byte,
  output logic                 last_byte
);

  logic [BYTE_W-1:0] source_address;
  logic [BYTE_W-1:0] target_address;
  logic [NUM_VALUES-1:0][VALUE_W-1:0] values;
  logic push;
  logic pop;
  frame_desc_t wr_desc;
  frame_desc_t rd_desc;
  queue_status_t q_status;
  back_status_t back_status;

  assign cfg_ready = 1'b1;
  assign in_stall = q_status.full;
  assign values = {value_9, value_8, value_7, value_6, value_5,
                   value_4, value_3, value_2, value_1, value_0};

  always_ff @(posedge clk) begin
    if (rst) begin
      source_address <= SOURCE_ADDRESS_RST;
      target_address <= TARGET_ADDRESS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SOURCE_ADDRESS: source_address <= cfg_data;
        REG_TARGET_ADDRESS: target_address <= cfg_data;
        default: ;
      endcase
    end
  end

  tfs_front u_front (
    .rst        (rst),
    .in_valid   (in_valid),
    .queue_full (q_status.full),
    .mode       (mode),
    .values     (values),
    .push       (push),
    .desc       (wr_desc)
  );

  tfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_desc (wr_desc),
    .pop     (pop),
    .rd_desc (rd_desc),
    .status  (q_status)
  );

  tfs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .queue_empty    (q_status.empty),
    .rd_desc        (rd_desc),
    .pop            (pop),
    .source_address (source_address),
    .target_address (target_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_byte     (frame_byte),
    .last_byte      (last_byte),
    .status         (back_status)
  );

  // queue cannot look full and empty at once
  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  // a checksum beat is never directly followed by another one
  a_no_double_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_byte |=> !(out_valid && last_byte))
    else $error("two checksum beats in a row");

  // once a non-final beat leaves, the next byte of the frame is already waiting
  a_frame_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_byte |=> out_valid)
    else $error("frame ended without a checksum beat");

endmodule

/* bench/tb_telemetry_frame_serializer_unit.sv */
// tb_telemetry_frame_serializer_unit: self-checking bench for the telemetry frame serializer
// depends on tfs_pkg and telemetry_frame_serializer_unit; frames are predicted byte by byte
// from the message beats and the address registers, then checked against every output beat
module tb_telemetry_frame_serializer_unit;
  import tfs_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PER_PHASE = 70;
  localparam int NUM_PHASES = 5;

  // message types with no frame layout
  localparam logic [MODE_W-1:0] MODE_UNDEF_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNDEF_7 = 3'd7;
  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [NUM_VALUES-1:0][VALUE_W-1:0] vals;
  } telemetry_msg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic last;
  } frame_beat_t;

  typedef struct packed {
    bit known;
    logic [BYTE_W-1:0] value;
  } checksum_note_t;

  typedef struct packed {
    telemetry_msg_t msg;
    checksum_note_t sum;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MODE_W-1:0] mode = '0;
  logic [VALUE_W-1:0] value_0 = '0;
  logic [VALUE_W-1:0] value_1 = '0;
  logic [VALUE_W-1:0] value_2 = '0;
  logic [VALUE_W-1:0] value_3 = '0;
  logic [VALUE_W-1:0] value_4 = '0;
  logic [VALUE_W-1:0] value_5 = '0;
  logic [VALUE_W-1:0] value_6 = '0;
  logic [VALUE_W-1:0] value_7 = '0;
  logic [VALUE_W-1:0] value_8 = '0;
  logic [VALUE_W-1:0] value_9 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [BYTE_W-1:0] frame_byte;
  logic last_byte;

  telemetry_frame_serializer_unit u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .value_0(value_0),
    .value_1(value_1),
    .value_2(value_2),
    .value_3(value_3),
    .value_4(value_4),
    .value_5(value_5),
    .value_6(value_6),
    .value_7(value_7),
    .value_8(value_8),
    .value_9(value_9),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .frame_byte(frame_byte),
    .last_byte(last_byte)
  );

  always #6 clk = ~clk;

  // predictor copy of the address registers
  logic [BYTE_W-1:0] model_src_addr;
  logic [BYTE_W-1:0] model_tgt_addr;

  frame_beat_t expected_frame_beats[$];
  checksum_note_t checksum_notes[$];
  directed_row_t directed_rows[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int messages_sent = 0;
  int silent_messages = 0;
  int beats_checked = 0;
  int address_settings = 1;

  telemetry_msg_t seen_msg;
  checksum_note_t seen_note;
  frame_beat_t want_beat;

  // bytes each value takes on the wire, zero where the layout has no such value
  function automatic int value_bytes(input logic [MODE_W-1:0] m, input int idx);
    case (m)
      MODE_STATUS: return (idx < 3) ? 2 : (idx == 3) ? 4 : (idx < 6) ? 1 : 0;
      MODE_SENSOR: return (idx < 9) ? 2 : 0;
      MODE_SENSOR2: return (idx < 2) ? 4 : (idx == 2) ? 2 : 0;
      MODE_RC: return 2;
      MODE_POWER: return (idx < 2) ? 2 : 0;
      MODE_MOTOR: return (idx < 8) ? 2 : 0;
      default: return 0;
    endcase
  endfunction

  function automatic void predict_frame(input telemetry_msg_t msg, input checksum_note_t note);
    logic [BYTE_W-1:0] fid;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] frame[$];
    int nb;
    case (msg.mode)
      MODE_STATUS: fid = FID_STATUS;
      MODE_SENSOR: fid = FID_SENSOR;
      MODE_SENSOR2: fid = FID_SENSOR2;
      MODE_RC: fid = FID_RC;
      MODE_POWER: fid = FID_POWER;
      MODE_MOTOR: fid = FID_MOTOR;
      default: return;
    endcase
    len = '0;
    for (int i = 0; i < NUM_VALUES; i++) len += BYTE_W'(value_bytes(msg.mode, i));
    frame = {SYNC_BYTE, model_src_addr, model_tgt_addr, fid, len};
    // payload goes out big-endian, cut to the layout width
    for (int i = 0; i < NUM_VALUES; i++) begin
      nb = value_bytes(msg.mode, i);
      for (int k = nb - 1; k >= 0; k--) frame.push_back(msg.vals[i][8*k +: 8]);
    end
    sum = '0;
    foreach (frame[j]) begin
      sum += frame[j];
      expected_frame_beats.push_back('{data: frame[j], last: 1'b0});
    end
    expected_frame_beats.push_back('{data: note.known ? note.value : sum, last: 1'b1});
  endfunction

  task automatic flag_mismatch(input string what, input frame_beat_t want,
                               input logic [BYTE_W-1:0] got_byte, input logic got_last);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected byte %02h last %0b, got byte %02h last %0b",
               what, want.data, want.last, got_byte, got_last);
  endtask

  // monitor: predicts on message beats, tracks register writes, checks frame beats
  always @(posedge clk) begin
    if (rst) begin
      model_src_addr = SOURCE_ADDRESS_RST;
      model_tgt_addr = TARGET_ADDRESS_RST;
      quiet_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SOURCE_ADDRESS) model_src_addr = cfg_data;
        else if (cfg_index == REG_TARGET_ADDRESS) model_tgt_addr = cfg_data;
      end
      if (in_valid && !in_stall) begin
        seen_msg.mode = mode;
        seen_msg.vals = {value_9, value_8, value_7, value_6, value_5,
                         value_4, value_3, value_2, value_1, value_0};
        seen_note = checksum_notes.pop_front();
        messages_sent++;
        if (value_bytes(seen_msg.mode, 0) == 0) silent_messages++;
        predict_frame(seen_msg, seen_note);
      end
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (expected_frame_beats.size() == 0) begin
          flag_mismatch("no frame pending", '0, frame_byte, last_byte);
        end else begin
          want_beat = expected_frame_beats.pop_front();
          if (want_beat.data !== frame_byte || want_beat.last !== last_byte)
            flag_mismatch("frame byte", want_beat, frame_byte, last_byte);
        end
      end
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: %0d cycles without a beat, %0d frame bytes still owed",
                 quiet_cycles, expected_frame_beats.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  task automatic send_msg(input telemetry_msg_t msg, input checksum_note_t note);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    checksum_notes.push_back(note);
    in_valid <= 1'b1;
    mode <= msg.mode;
    value_0 <= msg.vals[0];
    value_1 <= msg.vals[1];
    value_2 <= msg.vals[2];
    value_3 <= msg.vals[3];
    value_4 <= msg.vals[4];
    value_5 <= msg.vals[5];
    value_6 <= msg.vals[6];
    value_7 <= msg.vals[7];
    value_8 <= msg.vals[8];
    value_9 <= msg.vals[9];
    do @(posedge clk); while (in_stall);
  endtask

  // valid stays up across back-to-back register beats, caller drops it
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // wait for every owed byte, then let the block settle
  task automatic drain_frames();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_frame_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return VALUE_W'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  function automatic directed_row_t make_row(input logic [MODE_W-1:0] m,
                                             input logic [VALUE_W-1:0] even_val,
                                             input logic [VALUE_W-1:0] odd_val,
                                             input bit known, input logic [BYTE_W-1:0] sum);
    directed_row_t row;
    row.msg.mode = m;
    for (int i = 0; i < NUM_VALUES; i++) row.msg.vals[i] = (i % 2 == 0) ? even_val : odd_val;
    row.sum.known = known;
    row.sum.value = sum;
    return row;
  endfunction

  initial begin
    telemetry_msg_t msg;
    checksum_note_t no_note;
    logic [BYTE_W-1:0] src_plan[NUM_PHASES];
    logic [BYTE_W-1:0] tgt_plan[NUM_PHASES];

    no_note = '0;
    // checksums typed in below hold for the reset addresses 0x05 and 0xaf
    directed_rows.push_back(make_row(MODE_POWER, '0, '0, 1'b1, 8'h67));
    directed_rows.push_back(make_row(MODE_POWER, '1, '1, 1'b1, 8'h63));
    directed_rows.push_back(make_row(MODE_STATUS, '0, '0, 1'b1, 8'h6B));
    directed_rows.push_back(make_row(MODE_STATUS, '1, '1, 1'b1, 8'h5F));
    directed_rows.push_back(make_row(MODE_RC, '0, '0, 1'b1, 8'h75));
    directed_rows.push_back(make_row(MODE_RC, '1, '1, 1'b1, 8'h61));
    directed_rows.push_back(make_row(MODE_SENSOR, '0, '0, 1'b0, '0));
    directed_rows.push_back(make_row(MODE_SENSOR2, '0, '0, 1'b0, '0));
    directed_rows.push_back(make_row(MODE_MOTOR, '0, '0, 1'b0, '0));
    directed_rows.push_back(make_row(MODE_STATUS, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0));
    directed_rows.push_back(make_row(MODE_SENSOR, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0));
    directed_rows.push_back(make_row(MODE_SENSOR2, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0));
    directed_rows.push_back(make_row(MODE_SENSOR2, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0));
    directed_rows.push_back(make_row(MODE_RC, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0));
    directed_rows.push_back(make_row(MODE_RC, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0));
    directed_rows.push_back(make_row(MODE_POWER, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0));
    directed_rows.push_back(make_row(MODE_MOTOR, 32'h0001_FFFF, 32'hFFFF_0001, 1'b0, '0));
    // high bits beyond the layout width must be dropped
    directed_rows.push_back(make_row(MODE_SENSOR2, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0));
    directed_rows.push_back(make_row(MODE_STATUS, 32'hFEDC_BA98, 32'h0123_4567, 1'b0, '0));
    // no frame for the two undefined types
    directed_rows.push_back(make_row(MODE_UNDEF_6, '1, '1, 1'b0, '0));
    directed_rows.push_back(make_row(MODE_UNDEF_7, '0, '0, 1'b0, '0));
    directed_rows.push_back(make_row(MODE_POWER, 32'h0000_1234, 32'h0000_ABCD, 1'b0, '0));

    src_plan[0] = 8'h00; tgt_plan[0] = 8'h00;
    src_plan[1] = 8'hFF; tgt_plan[1] = 8'hFF;
    src_plan[2] = 8'h00; tgt_plan[2] = 8'hFF;
    src_plan[3] = BYTE_W'($urandom); tgt_plan[3] = BYTE_W'($urandom);
    src_plan[4] = 8'hFF; tgt_plan[4] = 8'h00;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) send_msg(directed_rows[r].msg, directed_rows[r].sum);
    drain_frames();

    for (int p = 0; p < NUM_PHASES; p++) begin
      put_reg(REG_SOURCE_ADDRESS, src_plan[p]);
      put_reg(REG_TARGET_ADDRESS, tgt_plan[p]);
      // writes to unused indexes must leave both addresses alone
      put_reg((p % 2 == 0) ? REG_SPARE_2 : REG_SPARE_3, BYTE_W'($urandom));
      cfg_valid <= 1'b0;
      address_settings++;
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 73; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 73; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      @(posedge clk);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        msg.mode = ($urandom_range(15) < 14) ? MODE_W'($urandom_range(5))
                                             : MODE_W'($urandom_range(7, 6));
        for (int i = 0; i < NUM_VALUES; i++) msg.vals[i] = pick_value();
        send_msg(msg, no_note);
      end
      drain_frames();
    end

    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_frame_beats.size() != 0) mismatches++;
    $display("sent %0d messages (%0d with no frame) under %0d address settings",
             messages_sent, silent_messages, address_settings);
    $display("checked %0d frame bytes, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
